// File: rtl/core/ahwp_pkg.sv
`timescale 1ns / 1ps

package ahwp_pkg;

	// Largest number of results that one item can cause.
	localparam int MAX_RESULTS = 4;
	localparam int IDX_W = $clog2(MAX_RESULTS);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	// Width of the assembled word: the last eight digits are kept.
	localparam int WORD_W = 32;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_X       = 8'h78;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_CHAR  = 3'd1,
		ERR_BAD_ZERO  = 3'd2,
		ERR_BAD_WORD  = 3'd3,
		ERR_EARLY_END = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		MODE_SKIP    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_ZERO    = 3'd2,
		MODE_WORD    = 3'd3
	} mode_t;

	// One result item.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		err_t       code;
	} result_t;

	// All results caused by one input item.
	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic [CNT_W-1:0]          count;
	} batch_t;

	// Status of the result buffer seen by the parser.
	typedef struct packed {
		logic             free;
		logic [CNT_W-1:0] remaining;
	} buf_stat_t;

endpackage

// File: rtl/core/ahwp_parser.sv
`timescale 1ns / 1ps

module ahwp_parser #(
	parameter int DIGITS_PER_WORD = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          text_char,
	input  logic                end_of_input,
	input  ahwp_pkg::buf_stat_t buf_stat,
	output logic                load,
	output ahwp_pkg::batch_t    batch
);
	import ahwp_pkg::*;

	localparam int NBYTES_RAW = (DIGITS_PER_WORD + 1) / 2;
	localparam int NBYTES = (NBYTES_RAW > MAX_RESULTS) ? MAX_RESULTS :
		((NBYTES_RAW < 1) ? 1 : NBYTES_RAW);
	localparam logic [4:0] DIGITS_W = 5'(DIGITS_PER_WORD);

	// Returns the digit value with a valid flag on top.
	function automatic logic [4:0] nibble_of(input logic [7:0] ch);
		logic [7:0] diff;
		begin
			diff = 8'd0;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				diff = ch - CH_ZERO;
				nibble_of = {1'b1, diff[3:0]};
			end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
				diff = ch - CH_LOWER_A + 8'd10;
				nibble_of = {1'b1, diff[3:0]};
			end else begin
				nibble_of = 5'd0;
			end
		end
	endfunction

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              end_s1;
	mode_t             mode_q, mode_d;
	logic [3:0]        dcnt_q, dcnt_d;
	logic [WORD_W-1:0] word_q, word_d;
	err_t              sticky_q, sticky_d;
	logic              commit;

	// The held item moves on once its results fit in the buffer.
	assign commit   = valid_s1 && ((batch.count == '0) || buf_stat.free);
	assign load     = commit && (batch.count != '0);
	assign in_stall = valid_s1 && !commit;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= text_char;
			end_s1  <= end_of_input;
		end
	end

	// Parser state, updated when the held item is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SKIP;
			dcnt_q   <= '0;
			word_q   <= '0;
			sticky_q <= ERR_NONE;
		end else if (commit) begin
			mode_q   <= mode_d;
			dcnt_q   <= dcnt_d;
			word_q   <= word_d;
			sticky_q <= sticky_d;
		end
	end

	// Next state and results of the held item.
	always_comb begin
		logic [4:0]        nib_info;
		logic              is_hex;
		logic [3:0]        nib;
		logic              take;
		logic [4:0]        cnt_base;
		logic [WORD_W-1:0] word_base;
		logic [4:0]        cnt_t;
		logic [WORD_W-1:0] word_t;
		logic              raise;
		err_t              raise_code;

		nib_info   = nibble_of(char_s1);
		is_hex     = nib_info[4];
		nib        = nib_info[3:0];
		take       = 1'b0;
		cnt_base   = '0;
		word_base  = '0;
		cnt_t      = '0;
		word_t     = '0;
		raise      = 1'b0;
		raise_code = ERR_NONE;
		mode_d     = mode_q;
		dcnt_d     = dcnt_q;
		word_d     = word_q;
		sticky_d   = sticky_q;
		batch      = '0;

		if (end_s1) begin
			// End of text: report an unfinished word, then the end status.
			if (sticky_q == ERR_NONE && (mode_q == MODE_ZERO || mode_q == MODE_WORD)) begin
				batch.res[0] = result_t'{kind: KIND_ERROR, data: 8'd0, last: 1'b0,
					code: ERR_EARLY_END};
				batch.res[1] = result_t'{kind: KIND_END, data: 8'd0, last: 1'b0,
					code: ERR_EARLY_END};
				batch.count  = CNT_W'(2);
			end else begin
				batch.res[0] = result_t'{kind: KIND_END, data: 8'd0, last: 1'b0,
					code: sticky_q};
				batch.count  = CNT_W'(1);
			end
			mode_d   = MODE_SKIP;
			dcnt_d   = '0;
			word_d   = '0;
			sticky_d = ERR_NONE;
		end else if (sticky_q == ERR_NONE) begin
			case (mode_q)
				MODE_COMMENT: begin
					if (char_s1 == CH_NEWLINE) begin
						mode_d = MODE_SKIP;
					end
				end
				MODE_ZERO: begin
					if (is_hex) begin
						// The leading zero is the first digit of the word.
						take     = 1'b1;
						cnt_base = 5'd1;
					end else if (char_s1 == CH_X) begin
						dcnt_d = '0;
						word_d = '0;
						mode_d = MODE_WORD;
					end else begin
						raise      = 1'b1;
						raise_code = ERR_BAD_ZERO;
					end
				end
				MODE_WORD: begin
					if (is_hex) begin
						take      = 1'b1;
						cnt_base  = {1'b0, dcnt_q};
						word_base = word_q;
					end else begin
						raise      = 1'b1;
						raise_code = ERR_BAD_WORD;
					end
				end
				default: begin
					mode_d = MODE_SKIP;
					if (char_s1 inside {CH_SPACE, CH_TAB, CH_NEWLINE}) begin
						mode_d = MODE_SKIP;
					end else if (char_s1 == CH_HASH) begin
						mode_d = MODE_COMMENT;
					end else if (char_s1 == CH_ZERO) begin
						mode_d = MODE_ZERO;
					end else if (is_hex) begin
						take = 1'b1;
					end else begin
						raise      = 1'b1;
						raise_code = ERR_BAD_CHAR;
					end
				end
			endcase

			// First error of the file: one report, then silence until the end.
			if (raise) begin
				sticky_d     = raise_code;
				batch.res[0] = result_t'{kind: KIND_ERROR, data: 8'd0, last: 1'b0,
					code: raise_code};
				batch.count  = CNT_W'(1);
			end

			// Shift in a digit and emit the word once it is full.
			if (take) begin
				word_t = {word_base[WORD_W-5:0], nib};
				cnt_t  = cnt_base + 5'd1;
				if (cnt_t < DIGITS_W) begin
					dcnt_d = cnt_t[3:0];
					word_d = word_t;
					mode_d = MODE_WORD;
				end else begin
					for (int k = 0; k < NBYTES; k++) begin
						batch.res[k] = result_t'{kind: KIND_DATA, data: word_t[8*k +: 8],
							last: (k == NBYTES - 1), code: ERR_NONE};
					end
					batch.count = CNT_W'(NBYTES);
					dcnt_d      = '0;
					word_d      = '0;
					mode_d      = MODE_SKIP;
				end
			end
		end
	end

endmodule

// File: rtl/core/ahwp_result_buf.sv
`timescale 1ns / 1ps

module ahwp_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ahwp_pkg::batch_t    batch,
	output ahwp_pkg::buf_stat_t buf_stat,
	output logic                out_valid,
	input  logic                out_stall,
	output ahwp_pkg::result_t   out_item
);
	import ahwp_pkg::*;

	result_t [MAX_RESULTS-1:0] res_q;
	logic [CNT_W-1:0]          rem_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      pop;

	assign out_valid = (rem_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_item  = res_q[idx_q];

	// A new batch may enter when the buffer is empty or hands over its last item.
	assign buf_stat.free      = (rem_q == '0) || ((rem_q == CNT_W'(1)) && pop);
	assign buf_stat.remaining = rem_q;

	// Count and read index of the pending results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= batch.count;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= batch.res;
		end
	end

endmodule

// File: rtl/core/ascii_hex_word_parser_unit.sv
`timescale 1ns / 1ps

// Hex text to binary word converter. Characters enter one per cycle while not
// stalled; a character is registered, parsed in the following cycle, and its
// results (up to four) are loaded into a result register and delivered one per
// cycle while out_stall is low, so the first result leaves after the input register
// and then the result register. Items that cause no result, such as the digits of a
// word, go on at one per cycle while earlier results drain. An item that causes
// results waits in the input register until the result register is empty or
// hands over its last item, so a word of eight digits sustains one character per
// cycle while out_stall is low. There is no clearing pass after reset.
module ascii_hex_word_parser_unit #(
	parameter int DIGITS_PER_WORD = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_char,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic       last_of_word,
	output logic [2:0] error_code
);
	import ahwp_pkg::*;

	logic      load;
	batch_t    batch;
	buf_stat_t buf_stat;
	result_t   out_item;

	// Character parser with its input register.
	ahwp_parser #(
		.DIGITS_PER_WORD(DIGITS_PER_WORD)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_char   (text_char),
		.end_of_input(end_of_input),
		.buf_stat    (buf_stat),
		.load        (load),
		.batch       (batch)
	);

	// Result register that delivers one item per cycle unless the output stalls.
	ahwp_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.batch    (batch),
		.buf_stat (buf_stat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	assign result_kind  = out_item.kind;
	assign data_byte    = out_item.data;
	assign last_of_word = out_item.last;
	assign error_code   = out_item.code;

	// A batch is loaded only when the buffer has room for it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> buf_stat.free)
		else $error("result batch loaded while results were pending");

	// The buffer never counts more results than one item can cause.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buf_stat.remaining <= CNT_W'(MAX_RESULTS))
		else $error("result count out of range");

	// Data bytes never carry an error code.
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_DATA) |-> error_code == ERR_NONE)
		else $error("data byte with error code");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ahwp_pkg::*;

	localparam int DIGITS_PER_WORD = 8;
	localparam int IDLE_PCT = 36;
	localparam int RANDOM_ITEMS = 280;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	// Tracks the parser state and holds the results still owed by the block.
	class hex_word_scoreboard;
		mode_t       mode;
		logic [3:0]  ndigits;
		logic [31:0] nibbles;
		err_t        sticky;
		result_t     owed_results[$];
		int unsigned failures;

		function new();
			clear_file();
			failures = 0;
		endfunction

		function void clear_file();
			mode = MODE_SKIP;
			ndigits = '0;
			nibbles = '0;
			sticky = ERR_NONE;
		endfunction

		function void owe(kind_t kind, logic [7:0] data, logic last, err_t code);
			result_t r;
			r.kind = kind;
			r.data = data;
			r.last = last;
			r.code = code;
			owed_results = {owed_results, r};
		endfunction

		function void raise(err_t code);
			sticky = code;
			owe(KIND_ERROR, 8'h00, 1'b0, code);
		endfunction

		function bit hex_value(logic [7:0] ch, output logic [3:0] nib);
			nib = '0;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				nib = 4'(ch - CH_ZERO);
				return 1'b1;
			end
			if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
				nib = 4'(ch - CH_LOWER_A + 8'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Shifts in one digit; a full word releases its bytes, lowest first.
		function void take_digit(logic [3:0] nib);
			int count;
			int nbytes;
			count = int'(ndigits) + 1;
			nibbles = {nibbles[27:0], nib};
			if (count < DIGITS_PER_WORD) begin
				ndigits = 4'(count);
				mode = MODE_WORD;
				return;
			end
			nbytes = (DIGITS_PER_WORD + 1) / 2;
			if (nbytes > 4)
				nbytes = 4;
			for (int k = 0; k < nbytes; k++)
				owe(KIND_DATA, nibbles[8*k +: 8], (k + 1 == nbytes), ERR_NONE);
			ndigits = '0;
			nibbles = '0;
			mode = MODE_SKIP;
		endfunction

		// Predicts the results of one accepted item. An item that arrives after
		// the file already failed causes nothing unless it is an end mark.
		function void note_char(logic [7:0] ch, logic eoi);
			logic [3:0] nib;
			bit is_hex;
			if (eoi) begin
				if (sticky == ERR_NONE && (mode == MODE_ZERO || mode == MODE_WORD))
					raise(ERR_EARLY_END);
				owe(KIND_END, 8'h00, 1'b0, sticky);
				clear_file();
				return;
			end
			if (sticky != ERR_NONE)
				return;
			is_hex = hex_value(ch, nib);
			case (mode)
				MODE_COMMENT: begin
					if (ch == CH_NEWLINE)
						mode = MODE_SKIP;
				end
				MODE_ZERO: begin
					if (is_hex) begin
						ndigits = 4'd1;
						nibbles = '0;
						take_digit(nib);
					end else if (ch == CH_X) begin
						ndigits = '0;
						nibbles = '0;
						mode = MODE_WORD;
					end else begin
						raise(ERR_BAD_ZERO);
					end
				end
				MODE_WORD: begin
					if (is_hex)
						take_digit(nib);
					else
						raise(ERR_BAD_WORD);
				end
				default: begin
					mode = MODE_SKIP;
					if (ch == CH_HASH) begin
						mode = MODE_COMMENT;
					end else if (ch == CH_ZERO) begin
						mode = MODE_ZERO;
					end else if (is_hex) begin
						ndigits = '0;
						nibbles = '0;
						take_digit(nib);
					end else if (ch != CH_SPACE && ch != CH_TAB && ch != CH_NEWLINE) begin
						raise(ERR_BAD_CHAR);
					end
				end
			endcase
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] data, logic last,
			logic [2:0] code);
			result_t want;
			if (owed_results.size() == 0) begin
				$error("result with none pending: kind %0d data %0h code %0d",
					kind, data, code);
				failures++;
				return;
			end
			want = owed_results.pop_front();
			if (kind !== want.kind) begin
				$error("result_kind: expected %0d, actual %0d", want.kind, kind);
				failures++;
			end
			if (data !== want.data) begin
				$error("data_byte: expected %0h, actual %0h", want.data, data);
				failures++;
			end
			if (last !== want.last) begin
				$error("last_of_word: expected %0d, actual %0d", want.last, last);
				failures++;
			end
			if (code !== want.code) begin
				$error("error_code: expected %0d, actual %0d", want.code, code);
				failures++;
			end
		endfunction

		function int pending();
			return owed_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_char = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] result_kind;
	logic [7:0] data_byte;
	logic       last_of_word;
	logic [2:0] error_code;

	hex_word_scoreboard sb;
	bit no_idle = 1'b0;
	int sent_items = 0;
	int quiet_cycles = 0;

	ascii_hex_word_parser_unit #(
		.DIGITS_PER_WORD(DIGITS_PER_WORD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_char(text_char),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.last_of_word(last_of_word),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random outside the calm stretch.
	always @(posedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
	end

	// Every delivered result is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_kind, data_byte, last_of_word, error_code);
	end

	// Ends the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one item, waits for it to be taken, then may leave a gap.
	task automatic push_item(input logic [7:0] ch, input logic eoi);
		in_valid <= 1'b1;
		text_char <= ch;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_char(ch, eoi);
		sent_items++;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_char(input logic [7:0] ch);
		push_item(ch, 1'b0);
	endtask

	// The character that goes with an end mark is ignored, so it is random.
	task automatic send_end();
		push_item(8'($urandom_range(255)), 1'b1);
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(15);
		return (v < 10) ? 8'(CH_ZERO + v) : 8'(CH_LOWER_A + v - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_NEWLINE;
		endcase
	endfunction

	// A word with an optional 0x prefix; a short one stops before it fills.
	task automatic send_word(input bit full);
		int ndig;
		ndig = full ? DIGITS_PER_WORD : $urandom_range(DIGITS_PER_WORD - 1);
		if ($urandom_range(2) == 0) begin
			send_char(CH_ZERO);
			send_char(CH_X);
		end
		for (int i = 0; i < ndig; i++)
			send_char(hex_char());
	endtask

	// One file: mostly well-formed words, with comments, blanks and some noise.
	task automatic random_file();
		int ntok;
		int pick;
		logic [7:0] ch;
		ntok = $urandom_range(1, 6);
		for (int t = 0; t < ntok; t++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_word(1'b1);
				repeat ($urandom_range(2))
					send_char(blank_char());
			end else if (pick < 67) begin
				send_char(CH_HASH);
				repeat ($urandom_range(4)) begin
					ch = 8'($urandom_range(255));
					if (ch == CH_NEWLINE)
						ch = 8'h80;
					send_char(ch);
				end
				send_char(CH_NEWLINE);
			end else if (pick < 77) begin
				repeat ($urandom_range(1, 3))
					send_char(blank_char());
			end else if (pick < 85) begin
				send_word(1'b0);
				send_char(($urandom_range(1) == 0) ? blank_char() : 8'($urandom_range(255)));
			end else if (pick < 92) begin
				send_char(8'($urandom_range(255)));
			end else begin
				send_char(CH_ZERO);
				send_char(8'($urandom_range(255)));
			end
		end
		// Now and then the text stops inside a word.
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(1) == 0)
				send_char(CH_ZERO);
			else
				send_word(1'b0);
		end
		send_end();
	endtask

	initial begin
		sb = new();
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Blanks, then a comment that holds a character which is bad elsewhere.
		send_char(CH_SPACE);
		send_char(CH_TAB);
		send_char(CH_NEWLINE);
		send_char(CH_HASH);
		send_char("G");
		send_char(CH_NEWLINE);
		// A word that starts with a leading zero, ending in a clean file.
		send_char(CH_ZERO);
		send_char("9");
		send_char("a");
		send_char("f");
		send_char("0");
		send_char("0");
		send_char("0");
		send_char("1");
		send_end();
		// A bad character between words.
		send_char(8'hFF);
		send_end();
		// A leading zero followed by neither a digit nor x.
		send_char(CH_ZERO);
		send_char("G");
		send_end();
		// A word broken by a bad character.
		send_char("1");
		send_char(8'h00);
		send_end();
		// The text ends right after a leading zero.
		send_char(CH_ZERO);
		send_end();

		// Random files, with a calm stretch where neither side idles.
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			no_idle = (sent_items >= 100 && sent_items < 160);
			random_file();
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
